// ===== rtl/dsmt_pkg.sv =====
// Shared types, command codes and the log-add correction table for the
// disjoint-set merge table. No dependencies; every other rtl file imports it.
package dsmt_pkg;

    localparam int TARGETS      = 256;
    localparam int INDEX_BITS   = $clog2(TARGETS);
    localparam int SIZE_BITS    = $clog2(TARGETS + 1);
    localparam int STEP_BITS    = $clog2(TARGETS + 1);
    localparam int COUNT_BITS   = 32;
    localparam int MASS_BITS    = 32;
    localparam int CORR_ENTRIES = 256;
    localparam int CORR_LOG2    = $clog2(CORR_ENTRIES);
    localparam int SPAN_LOG2    = 20;
    localparam int CORR_BITS    = 32;

    localparam logic [2:0] CMD_CREATE     = 3'd0;
    localparam logic [2:0] CMD_MERGE      = 3'd1;
    localparam logic [2:0] CMD_ADD_COUNTS = 3'd2;
    localparam logic [2:0] CMD_ADD_MASS   = 3'd3;
    localparam logic [2:0] CMD_RESET_MASS = 3'd4;

    localparam logic signed [MASS_BITS-1:0] LOG_ZERO =
        {1'b1, {(MASS_BITS-1){1'b0}}};
    localparam logic signed [MASS_BITS-1:0] MASS_MAX =
        {1'b0, {(MASS_BITS-1){1'b1}}};
    localparam logic [SIZE_BITS-1:0] SIZE_LIMIT = SIZE_BITS'(TARGETS);
    localparam logic [STEP_BITS-1:0] STEP_LIMIT = STEP_BITS'(TARGETS);

    typedef struct packed {
        logic [2:0]                   cmd;
        logic [INDEX_BITS-1:0]        target_a;
        logic [INDEX_BITS-1:0]        target_b;
        logic [COUNT_BITS-1:0]        count_amount;
        logic signed [MASS_BITS-1:0]  mass_amount;
    } dsmt_in_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]        root_index;
        logic [SIZE_BITS-1:0]         set_size;
        logic [COUNT_BITS-1:0]        set_counts;
        logic signed [MASS_BITS-1:0]  set_mass;
    } dsmt_out_t;

    // One table row: parent link plus the per-root totals.
    typedef struct packed {
        logic [INDEX_BITS-1:0]        parent;
        logic [SIZE_BITS-1:0]         size;
        logic [COUNT_BITS-1:0]        count;
        logic signed [MASS_BITS-1:0]  mass;
    } dsmt_entry_t;

    typedef logic [CORR_BITS-1:0] corr_table_t [CORR_ENTRIES];

    // Unsigned shift-and-subtract quotient, used only while building the table.
    function automatic longint unsigned udiv64(longint unsigned num,
                                               longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        int              b;
        quo = 0;
        rem = 0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            quo = quo << 1;
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Builds ln(1 + exp(-d)) in Q16.16 at elaboration, in Q30 integer steps.
    function automatic corr_table_t build_corr_table();
        corr_table_t           tbl;
        longint unsigned       one;
        longint unsigned       d;
        longint unsigned       t;
        longint unsigned       term;
        longint                esum;
        longint unsigned       v;
        longint unsigned       z;
        longint unsigned       z2;
        longint unsigned       p;
        longint unsigned       lsum;
        longint unsigned       r;
        int                    i;
        int                    k;
        one = 64'd1 << 30;
        for (i = 0; i < CORR_ENTRIES; i++)
        begin
            d    = (longint'(i) << SPAN_LOG2) >> CORR_LOG2;
            t    = d << 10;
            term = one;
            esum = longint'(one);
            for (k = 1; k <= 16; k++)
            begin
                term = udiv64((term * t) >> 30, 64'(k));
                if (k[0])
                    esum = esum - longint'(term);
                else
                    esum = esum + longint'(term);
            end
            v = (esum > 0) ? longint'(esum) : 64'd0;
            for (k = 0; k < 4; k++)
                v = (v * v) >> 30;
            z    = udiv64(v << 30, 2 * one + v);
            z2   = (z * z) >> 30;
            p    = z;
            lsum = 0;
            for (k = 0; k < 16; k++)
            begin
                lsum = lsum + udiv64(p, 64'(2 * k + 1));
                p    = (p * z2) >> 30;
            end
            r      = 2 * lsum;
            tbl[i] = CORR_BITS'((r + (64'd1 << 13)) >> 14);
        end
        return tbl;
    endfunction

    localparam corr_table_t CORR_TABLE = build_corr_table();

endpackage

// ===== rtl/dsmt_log_add.sv =====
// Two-stage log-domain adder: max plus a log1p(exp(-d)) correction.
// Depends on dsmt_pkg for widths, log zero and the correction table.
module dsmt_log_add
(
    input  logic                                   clk,
    input  logic signed [dsmt_pkg::MASS_BITS-1:0]  op_a,
    input  logic signed [dsmt_pkg::MASS_BITS-1:0]  op_b,
    output logic signed [dsmt_pkg::MASS_BITS-1:0]  sum
);
    import dsmt_pkg::*;

    logic signed [MASS_BITS-1:0] hi;
    logic signed [MASS_BITS-1:0] lo;
    logic        [MASS_BITS:0]   diff;
    logic                        bypass_next;
    logic signed [MASS_BITS-1:0] bypass_val_next;

    logic                        bypass_reg;
    logic signed [MASS_BITS-1:0] bypass_val_reg;
    logic signed [MASS_BITS-1:0] hi_reg;
    logic        [MASS_BITS-1:0] diff_reg;

    logic [CORR_LOG2-1:0]        idx;
    logic [CORR_BITS-1:0]        corr;
    logic signed [MASS_BITS:0]   total;
    logic signed [MASS_BITS-1:0] sum_next;
    logic signed [MASS_BITS-1:0] sum_reg;

    always_comb
    begin
        hi              = (op_a > op_b) ? op_a : op_b;
        lo              = (op_a > op_b) ? op_b : op_a;
        diff            = {hi[MASS_BITS-1], hi} - {lo[MASS_BITS-1], lo};
        bypass_next     = (op_a == LOG_ZERO) || (op_b == LOG_ZERO);
        bypass_val_next = (op_a == LOG_ZERO) ? op_b : op_a;
    end

    always_ff @(posedge clk)
    begin
        bypass_reg     <= bypass_next;
        bypass_val_reg <= bypass_val_next;
        hi_reg         <= hi;
        diff_reg       <= diff[MASS_BITS-1:0];
    end

    // Differences of 16.0 or more get no correction.
    always_comb
    begin
        idx  = diff_reg[SPAN_LOG2-1 -: CORR_LOG2];
        corr = (diff_reg[MASS_BITS-1:SPAN_LOG2] == '0) ? CORR_TABLE[idx] : '0;
        total = {hi_reg[MASS_BITS-1], hi_reg} + $signed({1'b0, corr[MASS_BITS-1:0]});
        if (bypass_reg)
            sum_next = bypass_val_reg;
        else if (total[MASS_BITS:MASS_BITS-1] == 2'b01)
            sum_next = MASS_MAX;
        else
            sum_next = total[MASS_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

// ===== rtl/disjoint_set_merge_table_unit.sv =====
// Top level of the disjoint-set merge table: command port, walk sequencer,
// entry memory. Depends on dsmt_pkg and dsmt_log_add.
//
// The unit keeps a union-find forest over 256 entries in one synchronous
// memory, each word holding a parent link, the set size, a saturating count
// total and a Q16.16 log mass. A command word is taken when start is high
// and busy is low; exactly one result word follows, shown on result for a
// single cycle with done high. The receiver cannot stall the unit, so it
// must take every result in that cycle. One command is in flight at a time.
// Create answers without a walk. Other commands walk from the entry to its
// root at one memory read per visited entry, so the walk depth sets how long
// they take: query and reset mass answer once the root is read, add counts
// and add mass then pass the log adder and a root write-back, and a merge
// walks both operands and, if their roots differ, takes those steps plus a
// write of the losing root. Under union by size the depth stays at most 8.
// Entries that were never created must not be addressed.
module disjoint_set_merge_table_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  dsmt_pkg::dsmt_in_t    request,
    output logic                  done,
    output dsmt_pkg::dsmt_out_t   result
);
    import dsmt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_WALK_A = 7'b0000010,
        S_WALK_B = 7'b0000100,
        S_LA1    = 7'b0001000,
        S_LA2    = 7'b0010000,
        S_APPLY  = 7'b0100000,
        S_LOSER  = 7'b1000000
    } state_t;

    state_t                      state_reg, state_next;
    dsmt_in_t                    req_reg, req_next;
    logic [INDEX_BITS-1:0]       cur_reg, cur_next;
    logic [STEP_BITS-1:0]        steps_reg, steps_next;
    logic [INDEX_BITS-1:0]       root_reg, root_next;
    dsmt_entry_t                 root_data_reg, root_data_next;
    logic [INDEX_BITS-1:0]       los_reg, los_next;
    dsmt_entry_t                 los_data_reg, los_data_next;
    logic signed [MASS_BITS-1:0] la_a_reg, la_a_next;
    logic signed [MASS_BITS-1:0] la_b_reg, la_b_next;
    logic                        done_reg, done_next;
    dsmt_out_t                   result_reg, result_next;

    // Entry memory: one write port, one registered read port.
    dsmt_entry_t                 mem [TARGETS];
    dsmt_entry_t                 rdata_reg;
    logic [INDEX_BITS-1:0]       rd_addr;
    logic                        wr_en;
    logic [INDEX_BITS-1:0]       wr_addr;
    dsmt_entry_t                 wr_data;

    logic signed [MASS_BITS-1:0] la_sum;
    logic                        at_root;
    logic [SIZE_BITS:0]          size_sum;
    logic [COUNT_BITS:0]         count_sum;
    logic [COUNT_BITS-1:0]       count_sat;
    logic [COUNT_BITS-1:0]       count_addend;
    dsmt_entry_t                 upd;

    dsmt_log_add u_log_add
    (
        .clk   (clk),
        .op_a  (la_a_reg),
        .op_b  (la_b_reg),
        .sum   (la_sum)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    // The walk stops at a self-linked entry or after TARGETS steps.
    assign at_root = (rdata_reg.parent == cur_reg) || (steps_reg == STEP_LIMIT);

    // Saturating count add; in a merge the addend is the losing root's count.
    always_comb
    begin
        count_addend = (req_reg.cmd == CMD_MERGE) ? los_data_reg.count : req_reg.count_amount;
        count_sum    = {1'b0, root_data_reg.count} + {1'b0, count_addend};
        count_sat    = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];
        size_sum     = {1'b0, root_data_reg.size} + {1'b0, los_data_reg.size};
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        root_next      = root_reg;
        root_data_next = root_data_reg;
        los_next       = los_reg;
        los_data_next  = los_data_reg;
        la_a_next      = la_a_reg;
        la_b_next      = la_b_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        rd_addr        = cur_reg;
        wr_en          = 1'b0;
        wr_addr        = root_reg;
        wr_data        = root_data_reg;
        upd            = root_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    cur_next   = request.target_a;
                    steps_next = '0;
                    rd_addr    = request.target_a;
                    if (request.cmd == CMD_CREATE)
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = request.target_a;
                        wr_data.parent = request.target_a;
                        wr_data.size   = SIZE_BITS'(1);
                        wr_data.count  = request.count_amount;
                        wr_data.mass   = request.mass_amount;
                        done_next      = 1'b1;
                        result_next.root_index = request.target_a;
                        result_next.set_size   = SIZE_BITS'(1);
                        result_next.set_counts = request.count_amount;
                        result_next.set_mass   = request.mass_amount;
                    end
                    else
                    begin
                        state_next = S_WALK_A;
                    end
                end
            end

            S_WALK_A:
            begin
                if (!at_root)
                begin
                    cur_next   = rdata_reg.parent;
                    rd_addr    = rdata_reg.parent;
                    steps_next = steps_reg + STEP_BITS'(1);
                end
                else
                begin
                    root_next      = cur_reg;
                    root_data_next = rdata_reg;
                    la_a_next      = rdata_reg.mass;
                    la_b_next      = req_reg.mass_amount;
                    result_next.root_index = cur_reg;
                    result_next.set_size   = rdata_reg.size;
                    result_next.set_counts = rdata_reg.count;
                    result_next.set_mass   = rdata_reg.mass;
                    case (req_reg.cmd)
                        CMD_MERGE:
                        begin
                            cur_next   = req_reg.target_b;
                            rd_addr    = req_reg.target_b;
                            steps_next = '0;
                            state_next = S_WALK_B;
                        end
                        CMD_ADD_COUNTS, CMD_ADD_MASS:
                        begin
                            state_next = S_LA1;
                        end
                        CMD_RESET_MASS:
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = cur_reg;
                            wr_data       = rdata_reg;
                            wr_data.mass  = LOG_ZERO;
                            result_next.set_mass = LOG_ZERO;
                            done_next     = 1'b1;
                            state_next    = S_IDLE;
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_WALK_B:
            begin
                if (!at_root)
                begin
                    cur_next   = rdata_reg.parent;
                    rd_addr    = rdata_reg.parent;
                    steps_next = steps_reg + STEP_BITS'(1);
                end
                else if (cur_reg == root_reg)
                begin
                    // Both operands already share a root: nothing changes.
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // The larger set wins; on equal sizes the first operand's root does.
                    if (root_data_reg.size < rdata_reg.size)
                    begin
                        root_next      = cur_reg;
                        root_data_next = rdata_reg;
                        los_next       = root_reg;
                        los_data_next  = root_data_reg;
                        la_a_next      = rdata_reg.mass;
                        la_b_next      = root_data_reg.mass;
                    end
                    else
                    begin
                        los_next       = cur_reg;
                        los_data_next  = rdata_reg;
                        la_a_next      = root_data_reg.mass;
                        la_b_next      = rdata_reg.mass;
                    end
                    state_next = S_LA1;
                end
            end

            S_LA1:
            begin
                state_next = S_LA2;
            end

            S_LA2:
            begin
                state_next = S_APPLY;
            end

            S_APPLY:
            begin
                case (req_reg.cmd)
                    CMD_MERGE:
                    begin
                        upd.size  = (size_sum > {1'b0, SIZE_LIMIT}) ? SIZE_LIMIT
                                                                   : size_sum[SIZE_BITS-1:0];
                        upd.count = count_sat;
                        upd.mass  = la_sum;
                        state_next = S_LOSER;
                    end
                    CMD_ADD_COUNTS:
                    begin
                        upd.count  = count_sat;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        upd.mass   = la_sum;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
                wr_en          = 1'b1;
                wr_addr        = root_reg;
                wr_data        = upd;
                root_data_next = upd;
                result_next.root_index = root_reg;
                result_next.set_size   = upd.size;
                result_next.set_counts = upd.count;
                result_next.set_mass   = upd.mass;
            end

            S_LOSER:
            begin
                // The absorbed root links under the winner and gives up its count and mass; its size stays.
                wr_en          = 1'b1;
                wr_addr        = los_reg;
                wr_data.parent = root_reg;
                wr_data.size   = los_data_reg.size;
                wr_data.count  = '0;
                wr_data.mass   = LOG_ZERO;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        cur_reg       <= cur_next;
        steps_reg     <= steps_next;
        root_reg      <= root_next;
        root_data_reg <= root_data_next;
        los_reg       <= los_next;
        los_data_reg  <= los_data_next;
        la_a_reg      <= la_a_next;
        la_b_reg      <= la_b_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== test/disjoint_set_merge_table_unit_tb.sv =====
// Self-checking testbench for disjoint_set_merge_table_unit: directed table, then random
// command words checked by a built-in union-find predictor. Needs dsmt_pkg and the unit.
`timescale 1ns / 100ps

module disjoint_set_merge_table_unit_tb;

    import dsmt_pkg::*;

    // Command codes that the package does not name. Codes 6 and 7 act as query.
    localparam logic [2:0] CMD_QUERY  = 3'd5;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    localparam int RANDOM_WORDS = 1500;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    dsmt_in_t  request;
    logic      done;
    dsmt_out_t result;

    disjoint_set_merge_table_unit dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Predictor state: the forest and the per-root totals, plus the log1p table.
    logic [INDEX_BITS-1:0]       link_of   [TARGETS];
    logic [SIZE_BITS-1:0]        members_of[TARGETS];
    logic [COUNT_BITS-1:0]       counts_of [TARGETS];
    logic signed [MASS_BITS-1:0] mass_of   [TARGETS];
    logic [31:0]                 log1p_corr[CORR_ENTRIES];

    dsmt_out_t pending_results[$];
    int        error_count;
    int        words_sent;
    int        results_seen;
    int        merges_sent;

    // ln(1 + exp(-d)) in Q16.16 for each table step, worked in Q30 integers.
    // exp(-d) is raised from exp(-d/16) by four squarings; ln(1+y) uses atanh.
    task automatic fill_log1p_table();
        longint unsigned one_q30;
        longint unsigned step_d;
        longint unsigned scaled;
        longint unsigned taylor_term;
        longint          exp_sum;
        longint unsigned y;
        longint unsigned z;
        longint unsigned z_sq;
        longint unsigned power;
        longint unsigned atanh_sum;
        one_q30 = 64'd1 << 30;
        for (int i = 0; i < CORR_ENTRIES; i++)
        begin
            step_d      = (longint'(i) << 20) / CORR_ENTRIES;
            scaled      = step_d << 10;
            taylor_term = one_q30;
            exp_sum     = longint'(one_q30);
            for (int k = 1; k <= 16; k++)
            begin
                taylor_term = ((taylor_term * scaled) >> 30) / longint'(k);
                exp_sum = (k % 2 == 1) ? exp_sum - longint'(taylor_term)
                                       : exp_sum + longint'(taylor_term);
            end
            y = (exp_sum > 0) ? longint'(exp_sum) : 64'd0;
            repeat (4) y = (y * y) >> 30;
            z         = (y << 30) / (2 * one_q30 + y);
            z_sq      = (z * z) >> 30;
            power     = z;
            atanh_sum = 0;
            for (int k = 0; k < 16; k++)
            begin
                atanh_sum = atanh_sum + power / longint'(2 * k + 1);
                power     = (power * z_sq) >> 30;
            end
            log1p_corr[i] = 32'(((2 * atanh_sum) + (64'd1 << 13)) >> 14);
        end
    endtask

    function automatic logic [COUNT_BITS-1:0] counts_saturated(
        logic [COUNT_BITS-1:0] x, logic [COUNT_BITS-1:0] y);
        logic [COUNT_BITS:0] total;
        total = {1'b0, x} + {1'b0, y};
        return total[COUNT_BITS] ? '1 : total[COUNT_BITS-1:0];
    endfunction

    // Log-domain sum: max plus the correction for the gap, saturated at the top.
    function automatic logic signed [MASS_BITS-1:0] log_sum(
        logic signed [MASS_BITS-1:0] x, logic signed [MASS_BITS-1:0] y);
        longint hi;
        longint lo;
        longint gap;
        longint slot;
        longint total;
        if (x == LOG_ZERO)
            return y;
        if (y == LOG_ZERO)
            return x;
        hi    = (x > y) ? longint'(x) : longint'(y);
        lo    = (x > y) ? longint'(y) : longint'(x);
        gap   = hi - lo;
        slot  = (gap * CORR_ENTRIES) >>> SPAN_LOG2;
        total = hi + ((slot < CORR_ENTRIES) ? longint'(log1p_corr[slot]) : 0);
        if (total > longint'(MASS_MAX))
            total = longint'(MASS_MAX);
        return MASS_BITS'(total);
    endfunction

    function automatic logic [INDEX_BITS-1:0] root_of(logic [INDEX_BITS-1:0] x);
        int steps;
        steps = 0;
        while (link_of[x] != x && steps < TARGETS)
        begin
            x = link_of[x];
            steps++;
        end
        return x;
    endfunction

    // Applies one accepted command word to the predicted table and returns the
    // word the unit should answer with.
    function automatic dsmt_out_t apply_command(dsmt_in_t w);
        logic [INDEX_BITS-1:0] winner;
        logic [INDEX_BITS-1:0] loser;
        logic [INDEX_BITS-1:0] swap;
        int                    joined;
        dsmt_out_t             answer;
        case (w.cmd)
            CMD_CREATE:
            begin
                winner             = w.target_a;
                link_of[winner]    = winner;
                members_of[winner] = 1;
                counts_of[winner]  = w.count_amount;
                mass_of[winner]    = w.mass_amount;
            end
            CMD_MERGE:
            begin
                winner = root_of(w.target_a);
                loser  = root_of(w.target_b);
                if (winner != loser)
                begin
                    // Ties stay with the first operand's root.
                    if (members_of[winner] < members_of[loser])
                    begin
                        swap   = winner;
                        winner = loser;
                        loser  = swap;
                    end
                    joined = int'(members_of[winner]) + int'(members_of[loser]);
                    members_of[winner] = (joined > TARGETS) ? SIZE_LIMIT : SIZE_BITS'(joined);
                    counts_of[winner]  = counts_saturated(counts_of[winner], counts_of[loser]);
                    mass_of[winner]    = log_sum(mass_of[winner], mass_of[loser]);
                    counts_of[loser]   = '0;
                    mass_of[loser]     = LOG_ZERO;
                    link_of[loser]     = winner;
                end
            end
            default:
            begin
                winner = root_of(w.target_a);
                if (w.cmd == CMD_ADD_COUNTS)
                    counts_of[winner] = counts_saturated(counts_of[winner], w.count_amount);
                else if (w.cmd == CMD_ADD_MASS)
                    mass_of[winner] = log_sum(mass_of[winner], w.mass_amount);
                else if (w.cmd == CMD_RESET_MASS)
                    mass_of[winner] = LOG_ZERO;
            end
        endcase
        answer.root_index = winner;
        answer.set_size   = members_of[winner];
        answer.set_counts = counts_of[winner];
        answer.set_mass   = mass_of[winner];
        return answer;
    endfunction

    // Directed table. Rows with a typed answer use it; the rest use the predictor.
    typedef struct {
        dsmt_in_t  word;
        bit        typed;
        dsmt_out_t answer;
    } directed_row_t;

    directed_row_t directed_rows[$];

    task automatic add_row(logic [2:0] cmd, int a, int b, logic [31:0] cnt,
                           logic [31:0] mass, bit typed, dsmt_out_t answer);
        directed_row_t row;
        row.word   = '{cmd: cmd, target_a: INDEX_BITS'(a), target_b: INDEX_BITS'(b),
                       count_amount: cnt, mass_amount: mass};
        row.typed  = typed;
        row.answer = answer;
        directed_rows = {directed_rows, row};
    endtask

    // Draws the wait before a word; every third hundred words run without gaps.
    function automatic int draw_gap(int n);
        return ((n / 100) % 3 == 2) ? 0 : $urandom_range(0, 8);
    endfunction

    // Hands one word to the unit and records its prediction when it is taken.
    task automatic send_word(dsmt_in_t w, bit typed, dsmt_out_t typed_answer);
        dsmt_out_t predicted;
        int        gap;
        gap = draw_gap(words_sent);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = apply_command(w);
        pending_results = {pending_results, (typed ? typed_answer : predicted)};
        words_sent++;
        if (w.cmd == CMD_MERGE)
            merges_sent++;
    endtask

    // Result checker: every done word is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word root %0d size %0d counts %h mass %h",
                         $time, result.root_index, result.set_size, result.set_counts,
                         result.set_mass);
                error_count++;
            end
            else
            begin
                dsmt_out_t wanted;
                wanted = pending_results.pop_front();
                if (result.root_index !== wanted.root_index)
                begin
                    $display("%0t: root_index expected %0d got %0d",
                             $time, wanted.root_index, result.root_index);
                    error_count++;
                end
                if (result.set_size !== wanted.set_size)
                begin
                    $display("%0t: set_size expected %0d got %0d",
                             $time, wanted.set_size, result.set_size);
                    error_count++;
                end
                if (result.set_counts !== wanted.set_counts)
                begin
                    $display("%0t: set_counts expected %h got %h",
                             $time, wanted.set_counts, result.set_counts);
                    error_count++;
                end
                if (result.set_mass !== wanted.set_mass)
                begin
                    $display("%0t: set_mass expected %h got %h",
                             $time, wanted.set_mass, result.set_mass);
                    error_count++;
                end
            end
        end
    end

    // Mass near a reference point keeps the log-add gap inside the table often.
    function automatic logic [31:0] draw_mass();
        case ($urandom_range(0, 9))
            0:       return LOG_ZERO;
            1:       return MASS_MAX;
            2, 3, 4: return 32'($signed($urandom_range(0, 32 << 16)) - (16 << 16));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] draw_count();
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return 32'h8000_0000 + $urandom_range(0, 255);
            2:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        dsmt_out_t none;
        dsmt_in_t  w;
        int        roll;
        int        limit_cycles;
        none         = '0;
        error_count  = 0;
        words_sent   = 0;
        results_seen = 0;
        merges_sent  = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        fill_log1p_table();
        for (int i = 0; i < TARGETS; i++)
        begin
            link_of[i]    = '0;
            members_of[i] = '0;
            counts_of[i]  = '0;
            mass_of[i]    = '0;
        end

        // Extremes of counts and mass, saturation, log zero, ties, merge within
        // one set, the spare command codes and a create over a live root.
        add_row(CMD_CREATE, 0, 0, 32'hFFFF_FFFF, MASS_MAX, 1,
                '{8'd0, 9'd1, 32'hFFFF_FFFF, MASS_MAX});
        add_row(CMD_CREATE, 255, 255, 32'd0, LOG_ZERO, 1,
                '{8'd255, 9'd1, 32'd0, LOG_ZERO});
        add_row(CMD_ADD_COUNTS, 0, 0, 32'd1, 32'd0, 1,
                '{8'd0, 9'd1, 32'hFFFF_FFFF, MASS_MAX});
        add_row(CMD_ADD_MASS, 0, 0, 32'd0, MASS_MAX, 1,
                '{8'd0, 9'd1, 32'hFFFF_FFFF, MASS_MAX});
        add_row(CMD_ADD_MASS, 255, 0, 32'd0, 32'h0005_0000, 1,
                '{8'd255, 9'd1, 32'd0, 32'h0005_0000});
        add_row(CMD_RESET_MASS, 0, 0, 32'd0, 32'd0, 1,
                '{8'd0, 9'd1, 32'hFFFF_FFFF, LOG_ZERO});
        add_row(CMD_ADD_MASS, 0, 0, 32'd0, 32'hFFFF_FFFF, 1,
                '{8'd0, 9'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        add_row(CMD_CREATE, 1, 0, 32'd10, 32'd0, 1, '{8'd1, 9'd1, 32'd10, 32'd0});
        add_row(CMD_CREATE, 2, 0, 32'd20, 32'h0001_0000, 1,
                '{8'd2, 9'd1, 32'd20, 32'h0001_0000});
        add_row(CMD_MERGE, 1, 2, 32'd0, 32'd0, 0, none);
        add_row(CMD_MERGE, 0, 1, 32'd0, 32'd0, 0, none);
        add_row(CMD_MERGE, 2, 0, 32'd0, 32'd0, 0, none);
        add_row(CMD_MERGE, 255, 2, 32'd0, 32'd0, 0, none);
        add_row(CMD_QUERY, 255, 0, 32'd0, 32'd0, 0, none);
        add_row(CMD_SPARE6, 0, 0, 32'd0, 32'd0, 0, none);
        add_row(CMD_SPARE7, 2, 0, 32'd0, 32'd0, 0, none);
        add_row(CMD_CREATE, 1, 0, 32'd7, 32'd0, 1, '{8'd1, 9'd1, 32'd7, 32'd0});
        add_row(CMD_QUERY, 0, 0, 32'd0, 32'd0, 0, none);
        add_row(CMD_ADD_COUNTS, 0, 0, 32'h8000_0000, 32'd0, 0, none);
        add_row(CMD_ADD_MASS, 2, 0, 32'd0, 32'h7FFF_0000, 0, none);
        add_row(CMD_RESET_MASS, 255, 0, 32'd0, 32'd0, 0, none);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].answer);

        // Create every entry once so that any index is legal from here on.
        for (int i = 0; i < TARGETS; i++)
        begin
            w = '{cmd: CMD_CREATE, target_a: INDEX_BITS'(i), target_b: INDEX_BITS'($urandom),
                  count_amount: draw_count(), mass_amount: draw_mass()};
            send_word(w, 1'b0, none);
        end

        // Mostly merges and updates on random entries, with occasional re-creates
        // that break sets apart again so the forest keeps changing shape.
        for (int n = 0; n < RANDOM_WORDS - TARGETS; n++)
        begin
            roll = $urandom_range(0, 99);
            w.target_a     = INDEX_BITS'($urandom);
            w.target_b     = INDEX_BITS'($urandom);
            w.count_amount = draw_count();
            w.mass_amount  = draw_mass();
            if (roll < 12)
                w.cmd = CMD_CREATE;
            else if (roll < 45)
                w.cmd = CMD_MERGE;
            else if (roll < 60)
                w.cmd = CMD_ADD_COUNTS;
            else if (roll < 78)
                w.cmd = CMD_ADD_MASS;
            else if (roll < 85)
                w.cmd = CMD_RESET_MASS;
            else if (roll < 95)
                w.cmd = CMD_QUERY;
            else
                w.cmd = (roll < 97) ? CMD_SPARE6 : CMD_SPARE7;
            send_word(w, 1'b0, none);
        end
        start <= 1'b0;

        limit_cycles = 0;
        while (pending_results.size() != 0 && limit_cycles < 5000)
        begin
            @(posedge clk);
            limit_cycles++;
        end
        repeat (40) @(posedge clk);

        $display("Sent %0d command words (%0d merges) and checked %0d result words.",
                 words_sent, merges_sent, results_seen);
        if (error_count == 0 && pending_results.size() == 0)
            $display("disjoint_set_merge_table_unit_tb: clean");
        else
            $display("disjoint_set_merge_table_unit_tb: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #100ms;
        $display("Timed out with %0d result words outstanding.", pending_results.size());
        $display("disjoint_set_merge_table_unit_tb: errors");
        $finish;
    end

endmodule
